// ----- rtl/bcs_pkg.sv -----
package bcs_pkg;

  localparam int BCS_UNIT_W      = 16;
  localparam int BCS_MAX_CLUSTER = 8;
  localparam int BCS_QUEUE_DEPTH = 2;

  typedef logic [BCS_UNIT_W-1:0] bcs_unit_t;

  localparam bcs_unit_t BCS_BLOCK_LO    = 16'h0980;
  localparam bcs_unit_t BCS_BLOCK_HI    = 16'h09FF;
  localparam bcs_unit_t BCS_CANDRABINDU = 16'h0981;
  localparam bcs_unit_t BCS_VIRAMA      = 16'h09CD;
  localparam bcs_unit_t BCS_ZWNJ        = 16'h200C;
  localparam bcs_unit_t BCS_SIGN_LO     = 16'h09BE;
  localparam bcs_unit_t BCS_SIGN_HI     = 16'h09C3;
  localparam bcs_unit_t BCS_VOWEL_LO    = 16'h0985;
  localparam bcs_unit_t BCS_VOWEL_HI    = 16'h098C;
  localparam bcs_unit_t BCS_DIGIT_LO    = 16'h09E6;
  localparam bcs_unit_t BCS_DIGIT_HI    = 16'h09EF;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_SIGN,
    CLS_VOWEL,
    CLS_VIRAMA,
    CLS_ZWNJ,
    CLS_CONS
  } bcs_cls_t;

  typedef struct packed {
    bcs_unit_t unit;
    logic      eot;
    bcs_cls_t  cls;
  } bcs_cmd_t;

  function automatic bcs_cls_t bcs_classify(bcs_unit_t u);
    bcs_cls_t c;
    if (u == BCS_ZWNJ) begin
      c = CLS_ZWNJ;
    end else if (u < BCS_BLOCK_LO || u > BCS_BLOCK_HI) begin
      c = CLS_OTHER;
    end else if (u == BCS_VIRAMA) begin
      c = CLS_VIRAMA;
    end else if ((u >= BCS_SIGN_LO && u <= BCS_SIGN_HI) || u == 16'h09C7 ||
                 u == 16'h09C8 || u == 16'h09CB || u == 16'h09CC) begin
      c = CLS_SIGN;
    end else if ((u >= BCS_VOWEL_LO && u <= BCS_VOWEL_HI) || u == 16'h098F ||
                 u == 16'h0990 || u == 16'h0993 || u == 16'h0994 ||
                 (u >= BCS_DIGIT_LO && u <= BCS_DIGIT_HI) || u == 16'h09F7) begin
      c = CLS_VOWEL;
    end else begin
      c = CLS_CONS;
    end
    return c;
  endfunction

endpackage

// ----- rtl/bcs_in_if.sv -----
interface bcs_in_if import bcs_pkg::*; ();
  logic      valid;
  logic      ready;
  bcs_unit_t code_unit;
  logic      end_of_text;

  modport source (output valid, output code_unit, output end_of_text, input ready);
  modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

// ----- rtl/bcs_out_if.sv -----
interface bcs_out_if import bcs_pkg::*; ();
  logic      valid;
  logic      ready;
  bcs_unit_t out_unit;
  logic      end_of_cluster;
  logic      last_of_run;

  modport source (output valid, output out_unit, output end_of_cluster,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_unit, input end_of_cluster,
                  input last_of_run, output ready);
endinterface

// ----- rtl/bcs_front.sv -----
// Classifies each request and queues it for the back end.
module bcs_front import bcs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  bcs_in_if.sink   in_ch,
  output logic     cmd_valid,
  output bcs_cmd_t cmd,
  input  logic     cmd_pop
);

  localparam int PTR_W = (BCS_QUEUE_DEPTH > 1) ? $clog2(BCS_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(BCS_QUEUE_DEPTH + 1);

  bcs_cmd_t         q_r [BCS_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  bcs_cmd_t         new_cmd;

  assign in_ch.ready = (cnt_r != CNT_W'(BCS_QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign cmd         = q_r[rd_ptr_r];

  always_comb begin
    new_cmd.unit = in_ch.code_unit;
    new_cmd.eot  = in_ch.end_of_text;
    new_cmd.cls  = bcs_classify(in_ch.code_unit);
  end

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(BCS_QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ----- rtl/bcs_back.sv -----
// Cluster buffer and drain sequencer; one unit per cycle in drain unless stalled.
module bcs_back import bcs_pkg::*; #(
  parameter int MAX_CLUSTER = BCS_MAX_CLUSTER
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  input  bcs_cmd_t cmd,
  output logic     cmd_pop,
  bcs_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_CLUSTER + 1);
  localparam int IDX_W = $clog2(MAX_CLUSTER);

  typedef enum logic [3:0] {
    ST_DECIDE = 4'b0001,
    ST_PRIME  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_ALONE  = 4'b1000
  } bcs_state_t;

  bcs_state_t       state_r, state_nxt;
  logic             phase_post_r, phase_post_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             last_virama_r, last_virama_nxt;
  logic             join_r, join_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  bcs_unit_t        unit_r, unit_nxt;
  logic             do_alone_r, do_alone_nxt;
  logic             do_append_r, do_append_nxt;
  logic             do_post_r, do_post_nxt;

  logic             out_valid_r, out_valid_nxt;
  bcs_unit_t        out_unit_r, out_unit_nxt;
  logic             out_eoc_r, out_eoc_nxt;
  logic             out_last_r, out_last_nxt;

  bcs_unit_t        clus_mem [MAX_CLUSTER];
  bcs_unit_t        rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  bcs_unit_t        wr_data;

  // plan for the request at the queue head
  logic             p_cons, p_append, p_alone, p_post, p_pre, full;

  // append and follow-up step, shared by the decide cycle and the pre-drain end
  logic             ap_go, ap_append, ap_alone, ap_post;
  logic [CNT_W-1:0] ap_base, ap_after;
  bcs_unit_t        ap_unit;

  logic             can_emit, is_end;

  assign can_emit = !out_valid_r || out_ch.ready;
  assign full     = (count_r == CNT_W'(MAX_CLUSTER));
  assign is_end   = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    p_cons   = (cmd.cls == CLS_CONS);
    p_append = (cmd.cls == CLS_SIGN) || (cmd.cls == CLS_ZWNJ) || p_cons ||
               ((cmd.cls == CLS_VIRAMA) && join_r && !cmd.eot);
    p_alone  = (cmd.cls == CLS_OTHER) || (cmd.cls == CLS_VOWEL) ||
               ((cmd.cls == CLS_VIRAMA) && !join_r);
    p_post   = (cmd.cls == CLS_SIGN) || (cmd.cls == CLS_ZWNJ) || cmd.eot;
    p_pre    = p_alone || (p_append && full) ||
               (p_cons && count_r != '0 && !last_virama_r && cmd.unit != BCS_CANDRABINDU);
  end

  always_comb begin
    state_nxt       = state_r;
    phase_post_nxt  = phase_post_r;
    count_nxt       = count_r;
    last_virama_nxt = last_virama_r;
    join_nxt        = join_r;
    idx_nxt         = idx_r;
    unit_nxt        = unit_r;
    do_alone_nxt    = do_alone_r;
    do_append_nxt   = do_append_r;
    do_post_nxt     = do_post_r;
    cmd_pop         = 1'b0;
    rd_addr         = idx_r;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = unit_r;
    ap_go           = 1'b0;
    ap_base         = '0;
    ap_append       = do_append_r;
    ap_alone        = do_alone_r;
    ap_post         = do_post_r;
    ap_unit         = unit_r;
    out_valid_nxt   = out_ch.ready ? 1'b0 : out_valid_r;
    out_unit_nxt    = out_unit_r;
    out_eoc_nxt     = out_eoc_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      ST_DECIDE: begin
        if (cmd_valid) begin
          cmd_pop       = 1'b1;
          unit_nxt      = cmd.unit;
          do_alone_nxt  = p_alone;
          do_append_nxt = p_append;
          do_post_nxt   = p_post;
          join_nxt      = p_cons && !cmd.eot;
          if (p_pre && count_r != '0) begin
            state_nxt      = ST_PRIME;
            phase_post_nxt = 1'b0;
            idx_nxt        = '0;
          end else begin
            ap_go     = 1'b1;
            ap_base   = p_pre ? '0 : count_r;
            ap_append = p_append;
            ap_alone  = p_alone;
            ap_post   = p_post;
            ap_unit   = cmd.unit;
          end
        end
      end
      ST_PRIME: begin
        // read of entry 0 lands in rd_data_r
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_unit_nxt  = rd_data_r;
          out_eoc_nxt   = is_end;
          out_last_nxt  = is_end &&
                          (phase_post_r || (!do_alone_r && !(do_post_r && do_append_r)));
          if (!is_end) begin
            idx_nxt = idx_r + IDX_W'(1);
            rd_addr = idx_r + IDX_W'(1);
          end else if (phase_post_r) begin
            count_nxt = '0;
            state_nxt = ST_DECIDE;
          end else begin
            ap_go   = 1'b1;
            ap_base = '0;
          end
        end
      end
      ST_ALONE: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_unit_nxt  = unit_r;
          out_eoc_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_DECIDE;
        end
      end
      default: begin
        state_nxt = ST_DECIDE;
      end
    endcase

    ap_after = ap_append ? (ap_base + CNT_W'(1)) : ap_base;
    if (ap_go) begin
      count_nxt = ap_after;
      if (ap_append) begin
        wr_en           = 1'b1;
        wr_addr         = ap_base[IDX_W-1:0];
        wr_data         = ap_unit;
        last_virama_nxt = (ap_unit == BCS_VIRAMA);
      end
      if (ap_alone) begin
        state_nxt = ST_ALONE;
      end else if (ap_post && ap_after != '0) begin
        state_nxt      = ST_PRIME;
        phase_post_nxt = 1'b1;
        idx_nxt        = '0;
      end else begin
        state_nxt = ST_DECIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_DECIDE;
      phase_post_r  <= 1'b0;
      count_r       <= '0;
      last_virama_r <= 1'b0;
      join_r        <= 1'b0;
      idx_r         <= '0;
      do_alone_r    <= 1'b0;
      do_append_r   <= 1'b0;
      do_post_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_post_r  <= phase_post_nxt;
      count_r       <= count_nxt;
      last_virama_r <= last_virama_nxt;
      join_r        <= join_nxt;
      idx_r         <= idx_nxt;
      do_alone_r    <= do_alone_nxt;
      do_append_r   <= do_append_nxt;
      do_post_r     <= do_post_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r     <= unit_nxt;
    out_unit_r <= out_unit_nxt;
    out_eoc_r  <= out_eoc_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      clus_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= clus_mem[rd_addr];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_unit       = out_unit_r;
  assign out_ch.end_of_cluster = out_eoc_r;
  assign out_ch.last_of_run    = out_last_r;

endmodule

// ----- rtl/bangla_cluster_segmenter.sv -----
// Bengali cluster segmenter: UTF-16 units in, cluster units out.
// A lone unit goes out from ST_ALONE; a cluster is read out of the buffer in ST_DRAIN.
// Back end: a request that emits nothing returns to ST_DECIDE; a cluster drain primes the
// single buffer read port in ST_PRIME; the next request is popped only in ST_DECIDE.
// Input side takes up to 2 requests ahead of the back end (command queue).
// Reset: synchronous, active low; clears queue, counters and flags, buffer contents undefined.
module bangla_cluster_segmenter import bcs_pkg::*; #(
  parameter int MAX_CLUSTER = BCS_MAX_CLUSTER
) (
  input  logic      clk,
  input  logic      rst_n,
  bcs_in_if.sink    in_ch,
  bcs_out_if.source out_ch
);

  // front -> back command path
  logic     cmd_valid;
  bcs_cmd_t cmd;
  logic     cmd_pop;

  // Front end: class lookup per request, 2-deep queue.
  bcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back end: cluster buffer, flush/append plan, drain to the output register.
  bcs_back #(
    .MAX_CLUSTER (MAX_CLUSTER)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

  // back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // the final result of a request always closes a cluster
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last_of_run) |-> out_ch.end_of_cluster)
    else $error("last_of_run without end_of_cluster");

  // input stalls only when the queue holds work
  a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> cmd_valid)
    else $error("input stalled with empty queue");

endmodule

// ----- dv/tb_bangla_cluster_segmenter.sv -----
`timescale 1ns / 1ps

// Testbench for the Bengali cluster segmenter.
// A directed pass covers each unit class, conjuncts, buffer overflow and end of
// text. Random text follows under four idle/stall mixes. A local model predicts
// every emitted unit, and a monitor checks each one in order.
module tb_bangla_cluster_segmenter;
  import bcs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;     // well above the latency of a full drain

  // a few named code units for the directed part
  localparam bcs_unit_t U_KA      = 16'h0995;
  localparam bcs_unit_t U_RA      = 16'h09B0;
  localparam bcs_unit_t U_SSA     = 16'h09B7;
  localparam bcs_unit_t U_I_SIGN  = 16'h09BF;
  localparam bcs_unit_t U_AU_SIGN = 16'h09CC;
  localparam bcs_unit_t U_A       = 16'h0985;
  localparam bcs_unit_t U_ISSHAR  = 16'h09F7;
  localparam bcs_unit_t U_SPACE   = 16'h0020;
  localparam bcs_unit_t U_DANDA   = 16'h0964;

  typedef struct packed {
    bcs_unit_t unit;
    logic      eoc;
    logic      last;
  } cluster_unit_t;

  logic clk = 1'b0;
  logic rst_n;

  bcs_in_if  in_ch ();
  bcs_out_if out_ch ();

  bangla_cluster_segmenter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Units the block still owes us, oldest first.
  cluster_unit_t expected_units[$];

  // Shadow of the segmenter state.
  bcs_unit_t held[BCS_MAX_CLUSTER];
  int        held_len;
  logic      after_cons;   // last unit was a consonant, so a virama may join

  int idle_pct;    // chance per cycle that the sender holds back
  int stall_pct;   // chance per cycle that the receiver stalls
  int errors;
  int sent_units;
  int cycles;

  // ---------------------------------------------------------------------------
  // Segmentation model
  // ---------------------------------------------------------------------------
  function automatic bcs_cls_t unit_class(bcs_unit_t u);
    if (u == BCS_ZWNJ) return CLS_ZWNJ;
    if (u < BCS_BLOCK_LO || u > BCS_BLOCK_HI) return CLS_OTHER;
    case (u)
      BCS_VIRAMA: return CLS_VIRAMA;
      16'h09C7, 16'h09C8, 16'h09CB, 16'h09CC: return CLS_SIGN;
      16'h098F, 16'h0990, 16'h0993, 16'h0994, 16'h09F7: return CLS_VOWEL;
      default: ;
    endcase
    if (u >= 16'h09BE && u <= 16'h09C3) return CLS_SIGN;
    if (u >= 16'h0985 && u <= 16'h098C) return CLS_VOWEL;
    if (u >= 16'h09E6 && u <= 16'h09EF) return CLS_VOWEL;   // digits group with vowels
    return CLS_CONS;
  endfunction

  function automatic void emit_unit(bcs_unit_t u, logic eoc);
    cluster_unit_t r;
    r.unit = u;
    r.eoc  = eoc;
    r.last = 1'b0;
    expected_units.push_back(r);
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_len; i++) emit_unit(held[i], i == held_len - 1);
    held_len = 0;
  endfunction

  function automatic void hold_unit(bcs_unit_t u);
    if (held_len >= BCS_MAX_CLUSTER) flush_held();   // full buffer goes out on its own
    held[held_len] = u;
    held_len++;
  endfunction

  function automatic void segment_unit(bcs_unit_t u, logic eot);
    int            n_prior;
    cluster_unit_t tail;
    n_prior = expected_units.size();
    case (unit_class(u))
      CLS_OTHER, CLS_VOWEL: begin
        flush_held();
        emit_unit(u, 1'b1);
        after_cons = 1'b0;
      end
      CLS_SIGN, CLS_ZWNJ: begin
        hold_unit(u);
        flush_held();
        after_cons = 1'b0;
      end
      CLS_VIRAMA: begin
        if (after_cons) begin
          hold_unit(u);
        end else begin
          // stray virama: pending cluster goes out, virama stands alone
          flush_held();
          emit_unit(u, 1'b1);
        end
        after_cons = 1'b0;
      end
      default: begin
        // consonant starts a new cluster unless it follows a virama or is candrabindu
        if (held_len > 0 && held[held_len-1] != BCS_VIRAMA && u != BCS_CANDRABINDU)
          flush_held();
        hold_unit(u);
        after_cons = 1'b1;
      end
    endcase
    if (eot) begin
      if (held_len > 0 && held[held_len-1] == BCS_VIRAMA) held_len--;   // dangling virama
      flush_held();
      after_cons = 1'b0;
    end
    if (expected_units.size() > n_prior) begin
      tail = expected_units[expected_units.size()-1];
      tail.last = 1'b1;
      expected_units[expected_units.size()-1] = tail;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers and monitor
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after the accept.
  // valid stays high on return so back-to-back requests need no gap.
  task automatic send_unit(input bcs_unit_t u, input logic eot);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.code_unit   = u;
    in_ch.end_of_text = eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    segment_unit(u, eot);
    sent_units++;
    @(negedge clk);
  endtask

  // Hold the sender off until every owed unit has come out.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (expected_units.size() != 0) @(negedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  cluster_unit_t want;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_units.size() == 0) begin
        errors++;
        $error("unexpected result: out_unit=%h end_of_cluster=%b last_of_run=%b",
               out_ch.out_unit, out_ch.end_of_cluster, out_ch.last_of_run);
      end else begin
        want = expected_units.pop_front();
        if (out_ch.out_unit !== want.unit) begin
          errors++;
          $error("out_unit: expected %h, got %h", want.unit, out_ch.out_unit);
        end
        if (out_ch.end_of_cluster !== want.eoc) begin
          errors++;
          $error("end_of_cluster: expected %b, got %b", want.eoc, out_ch.end_of_cluster);
        end
        if (out_ch.last_of_run !== want.last) begin
          errors++;
          $error("last_of_run: expected %b, got %b", want.last, out_ch.last_of_run);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Random text
  // ---------------------------------------------------------------------------
  function automatic bcs_unit_t pick_in_block(bcs_cls_t want_cls);
    bcs_unit_t u;
    do u = BCS_BLOCK_LO + bcs_unit_t'($urandom_range(0, 127));
    while (unit_class(u) != want_cls);
    return u;
  endfunction

  // One well-formed word: syllables built from consonants, conjuncts,
  // candrabindu and vowel signs, with the odd vowel, digit, ASCII character or ZWNJ.
  task automatic send_word();
    int        n_syl;
    int        joins;
    int        kind;
    bcs_unit_t tail;
    n_syl = $urandom_range(1, 4);
    for (int s = 0; s < n_syl; s++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        send_unit(pick_in_block(CLS_CONS), 1'b0);
        // mostly short conjuncts, sometimes chains long enough to overflow
        joins = ($urandom_range(0, 9) < 2) ? $urandom_range(3, 6) : $urandom_range(0, 2);
        for (int j = 0; j < joins; j++) begin
          send_unit(BCS_VIRAMA, 1'b0);
          send_unit(pick_in_block(CLS_CONS), 1'b0);
        end
        if ($urandom_range(0, 99) < 20) send_unit(BCS_CANDRABINDU, 1'b0);
        if ($urandom_range(0, 99) < 50) send_unit(pick_in_block(CLS_SIGN), 1'b0);
      end else if (kind == 7) begin
        send_unit(pick_in_block(CLS_VOWEL), 1'b0);
      end else if (kind == 8) begin
        send_unit(bcs_unit_t'($urandom_range(16'h0020, 16'h007E)), 1'b0);
      end else begin
        send_unit(BCS_ZWNJ, 1'b0);
      end
    end
    // word boundary; sometimes the text ends here, dangling virama included
    case ($urandom_range(0, 3))
      0: tail = U_SPACE;
      1: tail = U_DANDA;
      2: tail = BCS_VIRAMA;
      default: tail = pick_in_block(CLS_CONS);
    endcase
    send_unit(tail, $urandom_range(0, 99) < 35);
  endtask

  task automatic test_random_text(input int send_idle, input int recv_stall,
                                  input int n_items);
    int first;
    int pick;
    first     = sent_units;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    while (sent_units - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_word();
      end else if (pick < 80) begin
        // anything at all, full 16-bit range
        send_unit(bcs_unit_t'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 9) == 0);
      end else if (pick < 90) begin
        send_unit(BCS_BLOCK_LO + bcs_unit_t'($urandom_range(0, 127)),
                  $urandom_range(0, 9) == 0);
      end else if (pick < 95) begin
        send_unit(BCS_VIRAMA, $urandom_range(0, 9) == 0);
      end else begin
        // broken conjunct: virama followed by a non-consonant
        send_unit(pick_in_block(CLS_CONS), 1'b0);
        send_unit(BCS_VIRAMA, 1'b0);
        send_unit(pick_in_block(CLS_VOWEL), $urandom_range(0, 1) == 1);
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Each class but the vowel sign on its own, plus the edges of the Bengali block.
  task automatic test_classes();
    send_unit(16'h0000, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h097F, 1'b0);
    send_unit(16'h0A00, 1'b0);
    send_unit(BCS_BLOCK_LO, 1'b0);   // lowest consonant
    send_unit(BCS_BLOCK_HI, 1'b0);   // closes the one ahead of it
    send_unit(U_A, 1'b0);
    send_unit(U_ISSHAR, 1'b0);
    send_unit(BCS_ZWNJ, 1'b0);
    send_unit(BCS_VIRAMA, 1'b0);     // stray virama
  endtask

  // ka + virama + ssa with candrabindu and a vowel sign; then virama + ZWNJ.
  task automatic test_conjuncts();
    send_unit(U_KA, 1'b0);
    send_unit(BCS_VIRAMA, 1'b0);
    send_unit(U_SSA, 1'b0);
    send_unit(BCS_CANDRABINDU, 1'b0);
    send_unit(U_I_SIGN, 1'b0);
    send_unit(U_KA, 1'b0);
    send_unit(BCS_VIRAMA, 1'b0);
    send_unit(BCS_ZWNJ, 1'b0);
  endtask

  // Eight held units, then a sign: overflow flush plus the sign alone, nine results.
  task automatic test_full_cluster();
    for (int i = 0; i < BCS_MAX_CLUSTER / 2; i++) begin
      send_unit(U_KA, 1'b0);
      send_unit(BCS_VIRAMA, 1'b0);
    end
    send_unit(U_AU_SIGN, 1'b0);
  endtask

  task automatic test_end_of_text();
    send_unit(BCS_CANDRABINDU, 1'b1);   // consonant flushed by end of text
    send_unit(U_RA, 1'b0);
    send_unit(BCS_VIRAMA, 1'b1);        // joined virama dropped at the end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.code_unit    = '0;
    in_ch.end_of_text  = 1'b0;
    held_len   = 0;
    after_cons = 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    errors     = 0;
    sent_units = 0;
    cycles     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_classes();
    test_conjuncts();
    test_full_cluster();
    test_end_of_text();
    wait_drained();

    test_random_text(0, 0, 85);
    test_random_text(70, 0, 85);
    test_random_text(0, 70, 85);
    test_random_text(24, 24, 85);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_units.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bcs_pkg.sv
rtl/bcs_in_if.sv
rtl/bcs_out_if.sv
rtl/bcs_front.sv
rtl/bcs_back.sv
rtl/bangla_cluster_segmenter.sv
dv/tb_bangla_cluster_segmenter.sv
